[sv/spq_pkg.sv]
package spq_pkg;

	localparam int DEPTH_DEF = 16;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_REMOVED  = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	typedef struct packed {
		logic signed [31:0] val;
		logic signed [31:0] prio;
	} entry_t;

	// broadcast to every cell in the cycle a word is accepted
	typedef struct packed {
		logic   upd;
		logic   remove;
		entry_t item;
	} cell_cmd_t;

endpackage

[sv/spq_cell.sv]
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_cmd_t cmd,
	input  logic               occupied,
	input  logic               left_lt,
	input  spq_pkg::entry_t    left_entry,
	input  spq_pkg::entry_t    right_entry,
	output logic               lt,
	output spq_pkg::entry_t    entry
);

	spq_pkg::entry_t entry_q;
	spq_pkg::entry_t entry_d;

	// empty slots count as lower, so the new word lands behind all equal priorities
	assign lt = !occupied || (entry_q.prio < cmd.item.prio);

	always_comb begin
		entry_d = entry_q;
		if (cmd.remove) begin
			entry_d = right_entry;
		end else if (lt && left_lt) begin
			entry_d = left_entry;
		end else if (lt) begin
			entry_d = cmd.item;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			entry_q <= entry_d;
		end
	end

	assign entry = entry_q;

endmodule

[sv/sorted_priority_queue.sv]
// Sorted priority queue: a row of DEPTH cells kept in descending priority order.
// Input channel (in_valid/in_ready): mode, item_value, item_priority. mode 0
// inserts a word behind every entry of greater or equal priority; mode 1 removes
// the head entry. Output channel (out_valid/out_ready): one result word per input
// word with status, removed value and priority (zero unless removed) and the
// count held afterwards. A full insert or empty remove returns status 2 or 3
// and leaves the contents untouched.
// Every cell compares its priority with the incoming one in parallel and either
// keeps its entry, takes the new one, or takes a neighbour's, so all cells update
// together. The result is registered and appears in the cycle after acceptance,
// and a new word can be accepted every cycle while the receiver takes results.
// in_ready = !out_valid || out_ready: when the receiver stalls, the held result
// blocks further input until it is taken.
// Reset clears the count and the output valid; cell contents need no reset.
module sorted_priority_queue #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               mode,
	input  logic signed [31:0] item_value,
	input  logic signed [31:0] item_priority,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [31:0] out_value,
	output logic signed [31:0] out_priority,
	output logic [4:0]         count
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       cnt_d;
	logic                out_valid_q;
	logic [1:0]          status_q;
	logic [1:0]          status_d;
	spq_pkg::entry_t     res_q;
	spq_pkg::entry_t     res_d;
	logic [4:0]          count_q;
	logic [31:0]         cnt_ext;
	logic                accept;
	logic                is_full;
	logic                is_empty;
	spq_pkg::cell_cmd_t  cmd;
	logic [DEPTH-1:0]    occ;
	logic [DEPTH-1:0]    lt;
	spq_pkg::entry_t     cells [DEPTH];

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign is_full  = (cnt_q == CW'(DEPTH));
	assign is_empty = (cnt_q == '0);

	always_comb begin
		cmd.item.val  = item_value;
		cmd.item.prio = item_priority;
		cmd.remove    = (mode == spq_pkg::MODE_REMOVE);
		cmd.upd       = accept && (cmd.remove ? !is_empty : !is_full);
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			assign occ[gi] = (CW'(gi) < cnt_q);
			if (gi == 0) begin : g_head
				spq_cell u_cell (
					.clk        (clk),
					.cmd        (cmd),
					.occupied   (occ[gi]),
					.left_lt    (1'b0),
					.left_entry (cmd.item),
					.right_entry(cells[(gi + 1) % DEPTH]),
					.lt         (lt[gi]),
					.entry      (cells[gi])
				);
			end else if (gi == DEPTH - 1) begin : g_tail
				spq_cell u_cell (
					.clk        (clk),
					.cmd        (cmd),
					.occupied   (occ[gi]),
					.left_lt    (lt[gi - 1]),
					.left_entry (cells[gi - 1]),
					.right_entry(cells[gi]),
					.lt         (lt[gi]),
					.entry      (cells[gi])
				);
			end else begin : g_mid
				spq_cell u_cell (
					.clk        (clk),
					.cmd        (cmd),
					.occupied   (occ[gi]),
					.left_lt    (lt[gi - 1]),
					.left_entry (cells[gi - 1]),
					.right_entry(cells[gi + 1]),
					.lt         (lt[gi]),
					.entry      (cells[gi])
				);
			end
		end
	endgenerate

	always_comb begin
		cnt_d    = cnt_q;
		res_d    = '0;
		status_d = spq_pkg::ST_INSERTED;
		if (cmd.remove) begin
			if (is_empty) begin
				status_d = spq_pkg::ST_EMPTY;
			end else begin
				status_d = spq_pkg::ST_REMOVED;
				res_d    = cells[0];
				cnt_d    = cnt_q - CW'(1);
			end
		end else begin
			if (is_full) begin
				status_d = spq_pkg::ST_FULL;
			end else begin
				cnt_d = cnt_q + CW'(1);
			end
		end
	end

	assign cnt_ext = 32'(cnt_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q       <= cnt_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			res_q    <= res_d;
			count_q  <= cnt_ext[4:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_value    = res_q.val;
	assign out_priority = res_q.prio;
	assign count        = count_q;

endmodule

[sv/spq_chk.sv]
module spq_chk #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         status,
	input logic signed [31:0] out_value,
	input logic signed [31:0] out_priority,
	input logic [4:0]         count
);

	localparam logic [31:0] DEPTH_W = 32'(DEPTH);

	// a held result must not change
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(count)
			&& $stable(out_value) && $stable(out_priority))
		else $error("result changed while stalled");

	// a result only appears after a word was accepted
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result without accepted word");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == spq_pkg::ST_EMPTY |->
			count == 5'd0 && out_value == 32'sd0 && out_priority == 32'sd0)
		else $error("empty reject malformed");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == spq_pkg::ST_FULL |-> count == DEPTH_W[4:0])
		else $error("full reject with wrong count");

	a_ins: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == spq_pkg::ST_INSERTED |->
			out_value == 32'sd0 && out_priority == 32'sd0)
		else $error("insert result carries data");

endmodule

bind sorted_priority_queue spq_chk #(.DEPTH(DEPTH)) u_spq_chk (.*);

[tb/sorted_priority_queue_tb.sv]
`timescale 1ns / 1ps

module sorted_priority_queue_tb;

	localparam int CAP        = spq_pkg::DEPTH_DEF;
	localparam int CYCLE_CAP  = 400000;
	localparam int RAND_WORDS = 1375;
	localparam int PHASE_LEN  = 50;

	typedef struct {
		logic [1:0]         st;
		logic signed [31:0] val;
		logic signed [31:0] prio;
		logic [4:0]         cnt;
	} queue_result_t;

	// model of the sorted row: entries held head first, plus results still owed
	class spq_scoreboard;
		logic signed [31:0] vals[$];
		logic signed [31:0] prios[$];
		queue_result_t      owed[$];

		function void note_word(logic m, logic signed [31:0] v, logic signed [31:0] p);
			queue_result_t r;
			int pos;
			r.val  = '0;
			r.prio = '0;
			if (m == spq_pkg::MODE_INSERT) begin
				if (prios.size() >= CAP) begin
					r.st = spq_pkg::ST_FULL;
				end else begin
					// go behind every entry of greater or equal priority
					pos = 0;
					while (pos < prios.size() && !(prios[pos] < p))
						pos++;
					vals.insert(pos, v);
					prios.insert(pos, p);
					r.st = spq_pkg::ST_INSERTED;
				end
			end else begin
				if (prios.size() == 0) begin
					r.st = spq_pkg::ST_EMPTY;
				end else begin
					r.val  = vals.pop_front();
					r.prio = prios.pop_front();
					r.st   = spq_pkg::ST_REMOVED;
				end
			end
			r.cnt = 5'(prios.size());
			owed.push_back(r);
		endfunction

		// returns an empty string when the word matches
		function string check_result(logic [1:0] st, logic signed [31:0] v,
				logic signed [31:0] p, logic [4:0] c);
			queue_result_t r;
			string msg;
			if (owed.size() == 0)
				return $sformatf("unexpected result word status=%0d count=%0d", st, c);
			r = owed.pop_front();
			msg = "";
			if (st !== r.st)
				msg = {msg, $sformatf(" status %0d/%0d", st, r.st)};
			if (v !== r.val)
				msg = {msg, $sformatf(" out_value %0d/%0d", v, r.val)};
			if (p !== r.prio)
				msg = {msg, $sformatf(" out_priority %0d/%0d", p, r.prio)};
			if (c !== r.cnt)
				msg = {msg, $sformatf(" count %0d/%0d", c, r.cnt)};
			if (msg != "")
				msg = {"got/want:", msg};
			return msg;
		endfunction

		function int owed_count();
			return owed.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               mode;
	logic signed [31:0] item_value;
	logic signed [31:0] item_priority;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic signed [31:0] out_value;
	logic signed [31:0] out_priority;
	logic [4:0]         count;

	spq_scoreboard sb;
	int            errors;
	int            cycles;
	int            tx_lim;
	int            rx_lim;

	sorted_priority_queue #(.DEPTH(CAP)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.item_value   (item_value),
		.item_priority(item_priority),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.out_value    (out_value),
		.out_priority (out_priority),
		.count        (count)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("sorted_priority_queue_tb failed");
			$finish;
		end
	end

	task automatic report(string msg);
		errors++;
		if (errors <= 50)
			$display("ERROR %0t: %s", $time, msg);
	endtask

	task automatic send_word(logic m, logic signed [31:0] v, logic signed [31:0] p);
		int gap;
		gap = $urandom_range(0, tx_lim);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      <= 1'b1;
		mode          <= m;
		item_value    <= v;
		item_priority <= p;
		do @(posedge clk); while (!in_ready);
		sb.note_word(m, v, p);
	endtask

	function automatic logic signed [31:0] pick_priority();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return $signed(32'($urandom_range(0, 7))) - 4;   // plenty of ties
		if (sel < 8) begin
			case ($urandom_range(0, 3))
				0: return 32'sh7fffffff;
				1: return 32'sh80000000;
				2: return 32'sd0;
				default: return -32'sd1;
			endcase
		end
		return $urandom;
	endfunction

	task automatic run_directed();
		send_word(spq_pkg::MODE_REMOVE, $urandom, $urandom);        // remove from empty
		send_word(spq_pkg::MODE_INSERT, 32'sh7fffffff, 32'sh7fffffff);
		send_word(spq_pkg::MODE_INSERT, 32'sh80000000, 32'sh80000000);
		send_word(spq_pkg::MODE_INSERT, 32'sd0, 32'sd0);
		send_word(spq_pkg::MODE_INSERT, -32'sd1, -32'sd1);
		send_word(spq_pkg::MODE_INSERT, 32'sd1, 32'sd0);              // ties keep arrival order
		send_word(spq_pkg::MODE_INSERT, 32'sd2, 32'sd0);
		send_word(spq_pkg::MODE_INSERT, 32'sd3, 32'sh7fffffff);
		send_word(spq_pkg::MODE_INSERT, 32'sd4, 32'sh80000000);
		for (int i = 0; i < CAP - 8; i++)
			send_word(spq_pkg::MODE_INSERT, $urandom,
				$signed(32'($urandom_range(0, 2))) - 1);
		send_word(spq_pkg::MODE_INSERT, $urandom, $urandom);        // insert when full
		for (int i = 0; i < 7; i++)
			send_word(spq_pkg::MODE_REMOVE, $urandom, $urandom);
	endtask

	task automatic run_random();
		int ins_pct;
		for (int i = 0; i < RAND_WORDS; i++) begin
			if (i % PHASE_LEN == 0) begin
				case ($urandom_range(0, 2))
					0: ins_pct = 80;
					1: ins_pct = 50;
					default: ins_pct = 20;
				endcase
				case ($urandom_range(0, 2))
					0: tx_lim = 0;
					1: tx_lim = 3;
					default: tx_lim = 12;
				endcase
				case ($urandom_range(0, 2))
					0: rx_lim = 0;
					1: rx_lim = 3;
					default: rx_lim = 12;
				endcase
			end
			if ($urandom_range(1, 100) <= ins_pct)
				send_word(spq_pkg::MODE_INSERT, $urandom, pick_priority());
			else
				send_word(spq_pkg::MODE_REMOVE, $urandom, $urandom);
		end
	endtask

	// result side: random stalls, check at each accepted word
	initial begin
		string msg;
		int gap;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = $urandom_range(0, rx_lim);
			@(negedge clk);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			msg = sb.check_result(status, out_value, out_priority, count);
			if (msg != "")
				report(msg);
		end
	end

	initial begin
		sb            = new();
		errors        = 0;
		cycles        = 0;
		tx_lim        = 12;
		rx_lim        = 12;
		clk           = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		mode          = spq_pkg::MODE_INSERT;
		item_value    = '0;
		item_priority = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();
		run_random();
		@(negedge clk);
		in_valid <= 1'b0;

		while (sb.owed_count() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.owed_count() != 0)
			report($sformatf("%0d result words never arrived", sb.owed_count()));
		if (errors == 0)
			$display("sorted_priority_queue_tb passed");
		else
			$display("sorted_priority_queue_tb failed");
		$finish;
	end

endmodule
